[rtl/core/mte_pkg.sv]
package mte_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned InLenW = 4;
  localparam int unsigned PatW = 9;
  localparam int unsigned OpW = 2;
  localparam int unsigned SymW = 2;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned ElemIdxW = 4;

  typedef enum logic [OpW-1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [SymW-1:0] {
    SYM_DOT        = 2'd0,
    SYM_DASH       = 2'd1,
    SYM_LETTER_GAP = 2'd2,
    SYM_WORD_GAP   = 2'd3
  } sym_e;

  localparam logic [CharW-1:0] CharLowA = 8'h61;
  localparam logic [CharW-1:0] CharLowZ = 8'h7a;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  function automatic logic is_separator(logic [CharW-1:0] c);
    logic sep;
    unique case (c)
      8'h20, 8'h09, 8'h0a,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h2c, 8'h2e, 8'h26, 8'h2a, 8'h25, 8'h3f, 8'h21, 8'h3b, 8'h2f, 8'h2d,
      8'h27, 8'h40, 8'h22, 8'h24, 8'h23, 8'h3d, 8'h3e, 8'h3c, 8'h28, 8'h29,
      8'h5d, 8'h5b, 8'h7d, 8'h7b, 8'h3a: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

endpackage

[rtl/core/morse_text_encoder.sv]
// Text to Morse encoder. A beat with tuser OP_LOAD stores the code for the key in
// tdata[7:0] (length in tdata[11:8], saturated to MAX_CODE_LEN; element i in tdata[12+i],
// 1 dash, 0 dot); the first load of a key wins and the table is empty after reset, with
// no clearing pass. A beat with tuser OP_TEXT sends a character: a separator closes a
// pending word with one word gap, any other character (a..z upper-cased) emits its
// elements and a letter gap if its key is loaded. OP_END closes a pending word. Results
// leave one beat per cycle while the receiver is ready, the final beat of each input
// item carrying tlast; a character of length L gives L+1 beats, a gap one. The code
// table is a synchronous RAM read at the edge that takes the character, its data ready
// in the next cycle. A taken item waits in a held slot (one further item while the
// serialiser drains), then moves to the serialiser register, which offers its beats.
// Input beats that produce no output (loads, unknown characters) are taken every cycle
// while the slot is free; once an item waits in it, the input stalls until the final beat.
module morse_text_encoder #(
  parameter int unsigned MAX_CODE_LEN = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // char_code [7:0], code_len [11:8], code_pattern [20:12], zero [23:21]
  input  logic [mte_pkg::InDataW-1:0]  s_axis_tdata_i,
  // op [1:0]
  input  logic [mte_pkg::OpW-1:0]      s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // symbol [1:0], zero [7:2]
  output logic [mte_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import mte_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned EntW = LenW + PatW;

  logic [EntW-1:0]       mem_q [TableDepth];
  logic [EntW-1:0]       rd_q;
  logic [TableDepth-1:0] entry_valid_q;
  logic                  in_word_q, in_word_d;

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_gap_q, s1_gap_d;

  logic                  ser_valid_q, ser_valid_d;
  logic                  ser_gap_q, ser_gap_d;
  logic [LenW-1:0]       ser_len_q, ser_len_d;
  logic [LenW-1:0]       ser_idx_q, ser_idx_d;
  logic [PatW-1:0]       ser_pat_q, ser_pat_d;

  op_e                   op;
  logic [CharW-1:0]      in_char;
  logic [InLenW-1:0]     in_len;
  logic [PatW-1:0]       in_pat;
  logic [CharW-1:0]      key;
  logic [LenW-1:0]       len_sat;
  logic                  in_hs, out_hs, sep, load_new, push_gap, push_let;
  logic                  s1_adv, ser_last;
  logic [15:0]           pat_ext;
  sym_e                  sym;

  assign op      = op_e'(s_axis_tuser_i);
  assign in_char = s_axis_tdata_i[CharW-1:0];
  assign in_len  = s_axis_tdata_i[CharW+InLenW-1:CharW];
  assign in_pat  = s_axis_tdata_i[CharW+InLenW+PatW-1:CharW+InLenW];

  assign ser_last = ser_gap_q || (ser_idx_q == ser_len_q);
  assign s1_adv   = s1_valid_q && (!ser_valid_q || (m_axis_tready_i && ser_last));
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_hs    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_hs   = ser_valid_q && m_axis_tready_i;

  always_comb begin
    key = in_char;
    if (in_char >= CharLowA && in_char <= CharLowZ) begin
      key = in_char - CaseOffset;
    end
    sep      = is_separator(in_char);
    len_sat  = (in_len > InLenW'(MAX_CODE_LEN)) ? LenW'(MAX_CODE_LEN) : LenW'(in_len);
    load_new = in_hs && (op == OP_LOAD) && !entry_valid_q[in_char];
    push_gap = in_hs && in_word_q && (((op == OP_TEXT) && sep) || (op == OP_END));
    push_let = in_hs && (op == OP_TEXT) && !sep && entry_valid_q[key];
    in_word_d = in_word_q;
    if (in_hs && (op == OP_TEXT)) begin
      in_word_d = !sep;
    end else if (in_hs && (op == OP_END)) begin
      in_word_d = 1'b0;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_gap_d   = s1_gap_q;
    if (push_gap || push_let) begin
      s1_valid_d = 1'b1;
      s1_gap_d   = push_gap;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    ser_valid_d = ser_valid_q;
    ser_gap_d   = ser_gap_q;
    ser_len_d   = ser_len_q;
    ser_idx_d   = ser_idx_q;
    ser_pat_d   = ser_pat_q;
    if (s1_adv) begin
      ser_valid_d = 1'b1;
      ser_gap_d   = s1_gap_q;
      ser_len_d   = rd_q[LenW-1:0];
      ser_pat_d   = rd_q[EntW-1:LenW];
      ser_idx_d   = '0;
    end else if (out_hs) begin
      if (ser_last) begin
        ser_valid_d = 1'b0;
      end else begin
        ser_idx_d = ser_idx_q + LenW'(1);
      end
    end
  end

  always_comb begin
    pat_ext = {{(16 - PatW){1'b0}}, ser_pat_q};
    if (ser_gap_q) begin
      sym = SYM_WORD_GAP;
    end else if (ser_idx_q == ser_len_q) begin
      sym = SYM_LETTER_GAP;
    end else if (pat_ext[ElemIdxW'(ser_idx_q)]) begin
      sym = SYM_DASH;
    end else begin
      sym = SYM_DOT;
    end
  end

  assign m_axis_tvalid_o = ser_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - SymW){1'b0}}, sym};
  assign m_axis_tlast_o  = ser_last;

  always_ff @(posedge clk_i) begin
    if (load_new) begin
      mem_q[in_char] <= {in_pat, len_sat};
    end
    if (push_let) begin
      rd_q <= mem_q[key];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      in_word_q     <= 1'b0;
      s1_valid_q    <= 1'b0;
      s1_gap_q      <= 1'b0;
      ser_valid_q   <= 1'b0;
      ser_gap_q     <= 1'b0;
      ser_len_q     <= '0;
      ser_idx_q     <= '0;
      ser_pat_q     <= '0;
    end else begin
      if (load_new) begin
        entry_valid_q[in_char] <= 1'b1;
      end
      in_word_q   <= in_word_d;
      s1_valid_q  <= s1_valid_d;
      s1_gap_q    <= s1_gap_d;
      ser_valid_q <= ser_valid_d;
      ser_gap_q   <= ser_gap_d;
      ser_len_q   <= ser_len_d;
      ser_idx_q   <= ser_idx_d;
      ser_pat_q   <= ser_pat_d;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_valid_q && !ser_gap_q) |-> (ser_idx_q <= ser_len_q))
    else $error("serialiser index past code length");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && (op == OP_LOAD)) |=> entry_valid_q[$past(in_char)])
    else $error("loaded key not marked valid");

  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && ser_last && s1_valid_q) |=> ser_valid_q)
    else $error("held item lost at serialiser handover");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && ser_valid_q))
    else $error("input stalled with free buffer");

endmodule

[tb/testbench.sv]
module testbench;
  import mte_pkg::*;

  localparam int unsigned MaxCodeLen = 9;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned ErrorPrintLimit = 40;

  typedef struct packed {
    sym_e symbol;
    logic last;
  } morse_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // char_code [7:0], code_len [11:8], code_pattern [20:12], zero [23:21]
  logic [InDataW-1:0]  s_axis_tdata_i;
  // op [1:0]
  logic [OpW-1:0]      s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // symbol [1:0], zero [7:2]
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;

  string separators = " 0123456789,.&*%?!;/-'@\"$#=><()][}{:\n\t";

  logic              code_loaded [TableDepth];
  logic [InLenW-1:0] code_length [TableDepth];
  logic [PatW-1:0]   code_bits [TableDepth];
  logic              word_open;

  morse_beat_t symbols_due[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request;
  int unsigned hold_left;

  morse_text_encoder #(
    .MAX_CODE_LEN(MaxCodeLen)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic flag_error(string msg);
    if (error_count < ErrorPrintLimit) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic logic is_word_break(logic [CharW-1:0] c);
    for (int i = 0; i < separators.len(); i++) begin
      if (separators[i] == c) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic push_symbol(sym_e s);
    morse_beat_t b;
    b.symbol = s;
    b.last = 1'b0;
    symbols_due.push_back(b);
  endtask

  task automatic encode_beat(op_e op, logic [CharW-1:0] ch, logic [InLenW-1:0] len,
                             logic [PatW-1:0] pat);
    int unsigned before_cnt;
    logic [CharW-1:0] key;
    morse_beat_t b;
    before_cnt = symbols_due.size();
    case (op)
      OP_LOAD: begin
        if (!code_loaded[ch]) begin
          code_loaded[ch] = 1'b1;
          code_length[ch] = (len > MaxCodeLen) ? InLenW'(MaxCodeLen) : len;
          code_bits[ch] = pat;
        end
      end
      OP_TEXT: begin
        if (is_word_break(ch)) begin
          if (word_open) begin
            push_symbol(SYM_WORD_GAP);
            word_open = 1'b0;
          end
        end else begin
          word_open = 1'b1;
          key = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
          if (code_loaded[key]) begin
            for (int k = 0; k < code_length[key]; k++) begin
              push_symbol(code_bits[key][k] ? SYM_DASH : SYM_DOT);
            end
            push_symbol(SYM_LETTER_GAP);
          end
        end
      end
      OP_END: begin
        if (word_open) begin
          push_symbol(SYM_WORD_GAP);
          word_open = 1'b0;
        end
      end
      default: ;
    endcase
    if (symbols_due.size() > before_cnt) begin
      b = symbols_due.pop_back();
      b.last = 1'b1;
      symbols_due.push_back(b);
    end
  endtask

  task automatic send_beat(op_e op, logic [CharW-1:0] ch, logic [InLenW-1:0] len,
                           logic [PatW-1:0] pat);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {3'b000, pat, len, ch};
    s_axis_tuser_i = op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    encode_beat(op, ch, len, pat);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready_i = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    morse_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (symbols_due.size() == 0) begin
        flag_error($sformatf("unexpected beat, symbol %0d last %0b",
                             m_axis_tdata_o[SymW-1:0], m_axis_tlast_o));
      end else begin
        want = symbols_due.pop_front();
        if (m_axis_tdata_o[SymW-1:0] != want.symbol) begin
          flag_error($sformatf("symbol %0d, want %s", m_axis_tdata_o[SymW-1:0],
                               want.symbol.name()));
        end
        if (m_axis_tlast_o != want.last) begin
          flag_error($sformatf("last %0b, want %0b", m_axis_tlast_o, want.last));
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_beat(OP_TEXT, "E", 4'd0, 9'd0);
    send_beat(OP_END, 8'h00, 4'd0, 9'd0);
    send_beat(OP_END, 8'h00, 4'd0, 9'd0);
    send_beat(OP_TEXT, " ", 4'd0, 9'd0);
    send_beat(OP_LOAD, "A", 4'd2, 9'b000000010);
    send_beat(OP_LOAD, "A", 4'd1, 9'b000000001);
    send_beat(OP_LOAD, "Z", 4'd9, 9'h155);
    send_beat(OP_LOAD, 8'h00, 4'd0, 9'd0);
    send_beat(OP_LOAD, 8'hff, 4'd15, 9'h1ff);
    send_beat(OP_LOAD, "q", 4'd3, 9'd0);
    send_beat(OP_NONE, 8'hff, 4'd15, 9'h1ff);
    send_beat(OP_TEXT, "a", 4'd0, 9'd0);
    send_beat(OP_TEXT, "A", 4'd0, 9'd0);
    send_beat(OP_TEXT, "z", 4'd0, 9'd0);
    send_beat(OP_TEXT, 8'h00, 4'd0, 9'd0);
    send_beat(OP_TEXT, 8'hff, 4'd0, 9'd0);
    send_beat(OP_TEXT, "q", 4'd0, 9'd0);
    send_beat(OP_TEXT, ".", 4'd0, 9'd0);
    send_beat(OP_TEXT, "\t", 4'd0, 9'd0);
    send_beat(OP_TEXT, "Z", 4'd0, 9'd0);
    send_beat(OP_TEXT, "\n", 4'd0, 9'd0);
    send_beat(OP_TEXT, 8'h80, 4'd0, 9'd0);
    send_beat(OP_END, 8'h00, 4'd0, 9'd0);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_table_fill();
    send_idle_pct = 11;
    recv_stall_pct = 11;
    for (int i = 0; i < 26; i++) begin
      send_beat(OP_LOAD, 8'h41 + CharW'(i), InLenW'($urandom_range(15)),
                PatW'($urandom_range(511)));
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_text(int unsigned idle_pct, int unsigned stall_pct,
                                  int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    logic [CharW-1:0] ch;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_beat(OP_NONE, CharW'($urandom_range(255)), InLenW'($urandom_range(15)),
                  PatW'($urandom_range(511)));
      end else begin
        if (pick < 18) begin
          send_beat(OP_LOAD, CharW'($urandom_range(255)), InLenW'($urandom_range(15)),
                    PatW'($urandom_range(511)));
        end else if (pick < 26) begin
          send_beat(OP_END, CharW'($urandom_range(255)), InLenW'($urandom_range(15)),
                    PatW'($urandom_range(511)));
        end else begin
          if (pick < 44) begin
            ch = separators[$urandom_range(separators.len() - 1)];
          end else if (pick < 52) begin
            ch = CharW'($urandom_range(255));
          end else begin
            ch = 8'h41 + CharW'($urandom_range(25));
            if ($urandom_range(1) != 0) begin
              ch = ch | 8'h20;
            end
          end
          send_beat(OP_TEXT, ch, InLenW'($urandom_range(15)), PatW'($urandom_range(511)));
        end
        done++;
      end
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 7) begin
        send_beat(OP_TEXT, " ", 4'd0, 9'd0);
      end else begin
        send_beat(OP_TEXT, 8'h41 + CharW'($urandom_range(25)), 4'd0, 9'd0);
      end
    end
    send_beat(OP_END, 8'h00, 4'd0, 9'd0);
    stop_sending();
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = OP_NONE;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    word_open = 1'b0;
    for (int i = 0; i < TableDepth; i++) begin
      code_loaded[i] = 1'b0;
      code_length[i] = '0;
      code_bits[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_fill();
    test_random_text(0, 0, 80);
    test_random_text(48, 0, 80);
    test_random_text(0, 48, 80);
    test_random_text(11, 11, 80);
    test_backpressure();

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mte_pkg.sv
rtl/core/morse_text_encoder.sv
tb/testbench.sv
